@@ rtl/cdad_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar date add days package
// Shared types, constants and month length helpers for the date keeper.
// ----------------------------------------------------------------------------
package cdad_pkg;

  localparam int YEAR_BITS_DEF = 16;
  localparam int YEAR_RESET    = 1970;
  localparam logic [4:0] DAY_RESET   = 5'd1;
  localparam logic [3:0] MONTH_RESET = 4'd1;
  localparam logic [3:0] MONTHS      = 4'd12;

  typedef enum logic [1:0] {
    MODE_ADD_DAYS  = 2'd0,
    MODE_ADD_YEARS = 2'd1,
    MODE_LOAD      = 2'd2
  } cdad_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROLL,
    ST_OUT
  } cdad_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         load_day;
    logic [3:0]         load_month;
    logic [15:0]        load_year;
    logic signed [15:0] count;
  } cdad_in_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [8:0]  overflow_days;
  } cdad_out_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] first_months_len(input logic [1:0] n, input logic leap);
    logic [8:0] total;
    total = 9'd0;
    if (n >= 2'd1) total = total + 9'd31;
    if (n >= 2'd2) total = total + (leap ? 9'd29 : 9'd28);
    if (n >= 2'd3) total = total + 9'd31;
    return total;
  endfunction

endpackage

@@ rtl/calendar_date_add_days.sv @@
// ----------------------------------------------------------------------------
// Calendar date add days
// Date keeper that adds days or years to a stored date or loads a new one.
// ----------------------------------------------------------------------------
// The block holds a day, month and year (reset to January 1, 1970) and takes
// one item at a time. Loading a date and adding years pass from the input
// transfer through ST_OUT into the output register. Adding days first goes
// through ST_ROLL, where a single subtract and compare unit steps through
// the months one per cycle, then through ST_OUT; the largest day count crosses
// about 1080 months. The input stalls while an item is in work. Each result
// sits in an output register, so the next item is taken while it waits.
// Leap years are the years divisible by four.
module calendar_date_add_days
  import cdad_pkg::*;
#(
  parameter int YEAR_BITS = YEAR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cdad_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cdad_out_t out_data
);

  localparam int SW = ((YEAR_BITS > 16) ? YEAR_BITS : 16) + 2;
  localparam int LW = (YEAR_BITS > 16) ? YEAR_BITS : 16;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

  cdad_state_t          state_r, state_nxt;
  logic [4:0]           day_r, day_nxt;
  logic [3:0]           month_r, month_nxt;
  logic [YEAR_BITS-1:0] year_r, year_nxt;
  logic [15:0]          acc_r, acc_nxt;
  logic [8:0]           ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  cdad_out_t            out_data_r, out_data_nxt;

  logic                 in_xfer;
  logic signed [16:0]   day_sum;
  logic signed [SW-1:0] year_sum;
  logic [LW-1:0]        load_year_ext;
  logic [YEAR_BITS-1:0] load_year_sat;
  logic [3:0]           load_mon;
  logic [4:0]           load_len;
  logic [7:0]           load_day_cl;
  logic [4:0]           roll_len;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    day_sum  = $signed({12'd0, day_r}) + {in_data.count[15], in_data.count};
    year_sum = $signed({{(SW-YEAR_BITS){1'b0}}, year_r})
             + $signed({{(SW-16){in_data.count[15]}}, in_data.count});

    load_year_ext = LW'(in_data.load_year);
    if (load_year_ext > LW'(YEAR_MAX)) begin
      load_year_sat = YEAR_MAX;
    end else begin
      load_year_sat = load_year_ext[YEAR_BITS-1:0];
    end

    if (in_data.load_month < 4'd1) begin
      load_mon = 4'd1;
    end else if (in_data.load_month > MONTHS) begin
      load_mon = MONTHS;
    end else begin
      load_mon = in_data.load_month;
    end
    load_len = month_len(load_mon, load_year_sat[1:0] == 2'b00);
    if (in_data.load_day > {3'd0, load_len}) begin
      load_day_cl = {3'd0, load_len};
    end else if (in_data.load_day == 8'd0) begin
      load_day_cl = 8'd1;
    end else begin
      load_day_cl = in_data.load_day;
    end

    roll_len = month_len(month_r, year_r[1:0] == 2'b00);
  end

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ovf_nxt   = 9'd0;
          state_nxt = ST_OUT;
          case (in_data.mode)
            MODE_ADD_DAYS: begin
              if (day_sum < 17'sd1) begin
                acc_nxt = 16'd1;
              end else begin
                acc_nxt = day_sum[15:0];
              end
              state_nxt = ST_ROLL;
            end
            MODE_ADD_YEARS: begin
              if (year_sum < 0) begin
                year_nxt = '0;
              end else if (year_sum > $signed({{(SW-YEAR_BITS){1'b0}}, YEAR_MAX})) begin
                year_nxt = YEAR_MAX;
              end else begin
                year_nxt = year_sum[YEAR_BITS-1:0];
              end
            end
            MODE_LOAD: begin
              year_nxt  = load_year_sat;
              month_nxt = load_mon;
              day_nxt   = load_day_cl[4:0];
              if (in_data.load_day > load_day_cl) begin
                ovf_nxt = {1'b0, in_data.load_day - load_day_cl};
              end
              if (in_data.load_month > MONTHS) begin
                ovf_nxt = ovf_nxt
                        + first_months_len(2'(in_data.load_month - MONTHS),
                                           load_year_sat[1:0] == 2'b11);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROLL: begin
        if (acc_r > {11'd0, roll_len}) begin
          acc_nxt = acc_r - {11'd0, roll_len};
          if (month_r >= MONTHS) begin
            month_nxt = 4'd1;
            if (year_r != YEAR_MAX) begin
              year_nxt = year_r + 1'b1;
            end
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end else begin
          day_nxt   = acc_r[4:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.day           = day_r;
          out_data_nxt.month         = month_r;
          out_data_nxt.year          = 16'(year_r);
          out_data_nxt.overflow_days = ovf_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      day_r       <= DAY_RESET;
      month_r     <= MONTH_RESET;
      year_r      <= YEAR_BITS'(YEAR_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
